/* src/vsfp_pkg.sv */
// Shared types and constants for the vital sign frame parser.
`timescale 1ns / 1ps
`default_nettype none
package vsfp_pkg;

    localparam logic [7:0] HEADER_FIRST   = 8'h66;
    localparam logic [7:0] HEADER_SECOND  = 8'hCC;
    localparam logic [7:0] VITALS_ID      = 8'h01;
    localparam logic [7:0] VITALS_MIN_LEN = 8'd8;
    localparam int         N_VITALS       = 7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CSUM  = 2'd1;
    localparam logic [1:0] ST_OTHER = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  packet_id;
        logic [7:0]  heart_rate;
        logic [7:0]  breath_rate;
        logic [15:0] temperature_tenths;
        logic [7:0]  pressure_high;
        logic [7:0]  pressure_low;
        logic [7:0]  oxygen_level;
    } t_result;

endpackage
`default_nettype wire

/* src/vsfp_in_stage.sv */
// Input word register with stall back to the sender.
`timescale 1ns / 1ps
`default_nettype none
module vsfp_in_stage import vsfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_advance,
    output logic            o_stall,
    output logic            o_valid,
    output logic [7:0]      o_data_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       w_take;

    assign o_stall = r_valid && !i_advance;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= i_data_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data;

endmodule
`default_nettype wire

/* src/vsfp_deframer.sv */
// Frame state tracking, checksum and result decode for one word per cycle while i_advance is high.
`timescale 1ns / 1ps
`default_nettype none
module vsfp_deframer import vsfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_advance,
    output logic            o_is_check,
    output t_result         o_result
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_length, n_length;
    logic [7:0] r_index, n_index;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_id, n_id;
    logic [7:0] r_vital [N_VITALS];
    logic [N_VITALS-1:0] w_vital_we;

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_index  = r_index;
        n_sum    = r_sum;
        n_id     = r_id;
        case (r_phase)
            PH_HUNT: begin
                n_phase = (i_data_byte == HEADER_FIRST) ? PH_SECOND : PH_HUNT;
            end
            PH_SECOND: begin
                if (i_data_byte == HEADER_SECOND) begin
                    n_phase = PH_LENGTH;
                end else begin
                    n_phase = (i_data_byte == HEADER_FIRST) ? PH_SECOND : PH_HUNT;
                end
            end
            PH_LENGTH: begin
                n_length = i_data_byte;
                n_sum    = i_data_byte;
                n_index  = 8'd0;
                n_id     = 8'd0;
                n_phase  = (i_data_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum   = r_sum + i_data_byte;
                n_index = r_index + 8'd1;
                if (r_index == 8'd0) begin
                    n_id = i_data_byte;
                end
                if (n_index == r_length) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (i_data_byte == HEADER_FIRST) ? PH_SECOND : PH_HUNT;
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < N_VITALS; j++) begin
            w_vital_we[j] = i_advance && (r_phase == PH_PAYLOAD) && (r_index == 8'(j + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_length <= 8'd0;
            r_index  <= 8'd0;
            r_sum    <= 8'd0;
            r_id     <= 8'd0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_index  <= n_index;
            r_sum    <= n_sum;
            r_id     <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N_VITALS; j++) begin
            if (w_vital_we[j]) begin
                r_vital[j] <= i_data_byte;
            end
        end
    end

    always_comb begin
        o_result           = '0;
        o_result.packet_id = r_id;
        if (i_data_byte != r_sum) begin
            o_result.status = ST_CSUM;
        end else if (r_length == 8'd0 || r_id != VITALS_ID) begin
            o_result.status = ST_OTHER;
        end else if (r_length < VITALS_MIN_LEN) begin
            o_result.status = ST_SHORT;
        end else begin
            o_result.status             = ST_OK;
            o_result.heart_rate         = r_vital[0];
            o_result.breath_rate        = r_vital[1];
            o_result.temperature_tenths = {r_vital[2], r_vital[3]};
            o_result.pressure_high      = r_vital[4];
            o_result.pressure_low       = r_vital[5];
            o_result.oxygen_level       = r_vital[6];
        end
    end

    assign o_is_check = (r_phase == PH_CHECK);

endmodule
`default_nettype wire

/* src/vsfp_out_stage.sv */
// Result register toward the receiver.
`timescale 1ns / 1ps
`default_nettype none
module vsfp_out_stage import vsfp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid && i_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* src/vital_sign_frame_parser.sv */
// Top level: byte stream deframer for vital sign packets.
// Stages: input word register, then the result register that drives o_valid.
// Throughput: one word per cycle; a checksum word waits only while the result register
// is full and stalled.
// Reset: synchronous, active low; clears all valid flags and returns the parser to hunting.
`timescale 1ns / 1ps
`default_nettype none
module vital_sign_frame_parser import vsfp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_packet_id,
    output logic [7:0]       o_heart_rate,
    output logic [7:0]       o_breath_rate,
    output logic [15:0]      o_temperature_tenths,
    output logic [7:0]       o_pressure_high,
    output logic [7:0]       o_pressure_low,
    output logic [7:0]       o_oxygen_level
);

    logic       w_in_valid;
    logic       w_is_check;
    logic [7:0] w_byte;
    logic       w_advance;
    logic       w_out_free;
    t_result    w_res;
    t_result    w_out;

    vsfp_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_advance   (w_advance),
        .o_stall     (o_stall),
        .o_valid     (w_in_valid),
        .o_data_byte (w_byte)
    );

    vsfp_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (w_byte),
        .i_advance   (w_advance),
        .o_is_check  (w_is_check),
        .o_result    (w_res)
    );

    assign w_advance = w_in_valid && (!w_is_check || w_out_free);

    vsfp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_is_check),
        .i_result (w_res),
        .i_stall  (i_stall),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_result (w_out)
    );

    assign o_status             = w_out.status;
    assign o_packet_id          = w_out.packet_id;
    assign o_heart_rate         = w_out.heart_rate;
    assign o_breath_rate        = w_out.breath_rate;
    assign o_temperature_tenths = w_out.temperature_tenths;
    assign o_pressure_high      = w_out.pressure_high;
    assign o_pressure_low       = w_out.pressure_low;
    assign o_oxygen_level       = w_out.oxygen_level;

    a_check_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && w_is_check && !w_out_free) |-> o_stall)
        else $error("checksum word advanced into a full result register");

    a_ok_is_vitals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_packet_id == VITALS_ID))
        else $error("vitals status with another packet id");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_heart_rate == 8'd0 && o_temperature_tenths == 16'd0 && o_oxygen_level == 8'd0))
        else $error("vital fields set on a non-vitals result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("valid flags not cleared by reset");

endmodule
`default_nettype wire

/* dv/vital_sign_frame_parser_tb.sv */
// Self-checking testbench for the vital sign frame parser against a frame predictor.
`timescale 1ns / 1ps
module vital_sign_frame_parser_tb import vsfp_pkg::*; ();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int WORD_TARGET  = 1450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SECOND,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK
    } t_frame_phase;

    class frame_predictor;
        t_frame_phase phase;
        logic [7:0]   frame_len;
        logic [7:0]   payload_idx;
        logic [7:0]   byte_sum;
        logic [7:0]   frame_id;
        logic [7:0]   vital_bytes [N_VITALS];
        t_result      expected_frames [$];
        int           mismatches;

        function new();
            phase       = PH_HUNT;
            frame_len   = '0;
            payload_idx = '0;
            byte_sum    = '0;
            frame_id    = '0;
            mismatches  = 0;
            foreach (vital_bytes[k]) vital_bytes[k] = '0;
        endfunction

        function void take_byte(logic [7:0] b);
            t_result r;
            case (phase)
                PH_SECOND: begin
                    if (b == HEADER_SECOND) phase = PH_LENGTH;
                    else phase = (b == HEADER_FIRST) ? PH_SECOND : PH_HUNT;
                end
                PH_LENGTH: begin
                    frame_len   = b;
                    byte_sum    = b;
                    payload_idx = '0;
                    frame_id    = '0;
                    phase       = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    byte_sum = byte_sum + b;
                    if (payload_idx == 8'd0) frame_id = b;
                    else if (payload_idx <= N_VITALS) vital_bytes[payload_idx - 1] = b;
                    payload_idx = payload_idx + 8'd1;
                    if (payload_idx == frame_len) phase = PH_CHECK;
                end
                PH_CHECK: begin
                    phase = PH_HUNT;
                    r = '0;
                    r.packet_id = frame_id;
                    if (b != byte_sum) begin
                        r.status = ST_CSUM;
                    end else if (frame_len == 8'd0 || frame_id != VITALS_ID) begin
                        r.status = ST_OTHER;
                    end else if (frame_len < VITALS_MIN_LEN) begin
                        r.status = ST_SHORT;
                    end else begin
                        r.status             = ST_OK;
                        r.heart_rate         = vital_bytes[0];
                        r.breath_rate        = vital_bytes[1];
                        r.temperature_tenths = {vital_bytes[2], vital_bytes[3]};
                        r.pressure_high      = vital_bytes[4];
                        r.pressure_low       = vital_bytes[5];
                        r.oxygen_level       = vital_bytes[6];
                    end
                    expected_frames.push_back(r);
                end
                default: begin
                    phase = (b == HEADER_FIRST) ? PH_SECOND : PH_HUNT;
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                $error("%s expected %0h actual %0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void compare_frame(t_result seen);
            t_result want;
            if (expected_frames.size() == 0) begin
                $error("result with no frame pending: status %0h packet_id %0h",
                       seen.status, seen.packet_id);
                mismatches++;
                return;
            end
            want = expected_frames.pop_front();
            check_field("status", want.status, seen.status);
            check_field("packet_id", want.packet_id, seen.packet_id);
            check_field("heart_rate", want.heart_rate, seen.heart_rate);
            check_field("breath_rate", want.breath_rate, seen.breath_rate);
            check_field("temperature_tenths", want.temperature_tenths,
                        seen.temperature_tenths);
            check_field("pressure_high", want.pressure_high, seen.pressure_high);
            check_field("pressure_low", want.pressure_low, seen.pressure_low);
            check_field("oxygen_level", want.oxygen_level, seen.oxygen_level);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_packet_id;
    logic [7:0]  o_heart_rate;
    logic [7:0]  o_breath_rate;
    logic [15:0] o_temperature_tenths;
    logic [7:0]  o_pressure_high;
    logic [7:0]  o_pressure_low;
    logic [7:0]  o_oxygen_level;

    frame_predictor frames = new();
    bit             no_gaps       = 1'b0;
    bit             hold_off_req  = 1'b0;
    int             words_sent    = 0;
    int             cycle_count   = 0;

    vital_sign_frame_parser u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_data_byte          (i_data_byte),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_packet_id          (o_packet_id),
        .o_heart_rate         (o_heart_rate),
        .o_breath_rate        (o_breath_rate),
        .o_temperature_tenths (o_temperature_tenths),
        .o_pressure_high      (o_pressure_high),
        .o_pressure_low       (o_pressure_low),
        .o_oxygen_level       (o_oxygen_level)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit taken;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        frames.take_byte(b);
        words_sent++;
    endtask

    task automatic send_frame(input int len, input logic [7:0] body [256], input bit good_sum);
        logic [7:0] sum;
        sum = len[7:0];
        send_byte(HEADER_FIRST);
        send_byte(HEADER_SECOND);
        send_byte(len[7:0]);
        for (int k = 0; k < len; k++) begin
            sum = sum + body[k];
            send_byte(body[k]);
        end
        send_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    initial begin
        int         gap;
        bit         got;
        t_result    seen;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got                     = o_valid;
                seen.status             = o_status;
                seen.packet_id          = o_packet_id;
                seen.heart_rate         = o_heart_rate;
                seen.breath_rate        = o_breath_rate;
                seen.temperature_tenths = o_temperature_tenths;
                seen.pressure_high      = o_pressure_high;
                seen.pressure_low       = o_pressure_low;
                seen.oxygen_level       = o_oxygen_level;
                @(posedge i_clk);
            end while (!got);
            frames.compare_frame(seen);
        end
    end

    initial begin
        logic [7:0] body [256];
        int         pick;
        int         len;
        bit         held;
        held = 1'b0;
        foreach (body[k]) body[k] = 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad first byte, bad second byte, second 0x66 rechecked, zero length
        send_byte(8'h00);
        send_byte(HEADER_FIRST);
        send_byte(8'h55);
        send_byte(HEADER_FIRST);
        send_frame(0, body, 1'b1);
        body[0] = VITALS_ID;
        body[1] = 8'h00;
        body[2] = 8'hFF;
        body[3] = 8'hFF;
        body[4] = 8'hFF;
        body[5] = 8'h00;
        body[6] = 8'hFF;
        body[7] = 8'h00;
        send_frame(8, body, 1'b1);
        send_frame(1, body, 1'b1);
        send_frame(0, body, 1'b0);

        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 99) < 5) no_gaps = !no_gaps;
            if (!held && words_sent >= WORD_TARGET / 2) begin
                held         = 1'b1;
                no_gaps      = 1'b1;
                hold_off_req = 1'b1;
                repeat (30) send_frame(0, body, 1'b1);
                no_gaps      = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick < 14) begin
                send_byte(HEADER_FIRST);
                send_byte(8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 1) len = $urandom_range(100, 255);
                else if (pick < 10) len = 0;
                else len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) body[k] = 8'($urandom);
                if ($urandom_range(0, 99) < 60) body[0] = VITALS_ID;
                send_frame(len, body, $urandom_range(0, 99) < 85);
            end
        end
        i_valid <= 1'b0;

        while (frames.expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frames.mismatches == 0 && frames.expected_frames.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
